// ===== rtl/date_bucket_truncate_core_defines.svh =====
// Assertion macros for the date bucket truncation core.
// Taken in by the top level; the macros expect clk and rst_n in scope.
`ifndef DATE_BUCKET_TRUNCATE_CORE_DEFINES_SVH
`define DATE_BUCKET_TRUNCATE_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define DBT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("date bucket assertion failed");

// Next-cycle implication, checked out of reset.
`define DBT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("date bucket assertion failed");

`endif

// ===== rtl/dbt_pkg.sv =====
// Shared types, constants and arithmetic helpers for the date bucket core.
// No dependencies; every module of the block imports this package.
package dbt_pkg;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_TIME   = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_ORIGIN = 3'd3,
    ST_BEFORE = 3'd4
  } status_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MONTHS   = 2'd0;
  localparam logic [1:0] CFG_DAYS     = 2'd1;
  localparam logic [1:0] CFG_HAS_TIME = 2'd2;
  localparam logic [1:0] CFG_ORIGIN   = 2'd3;

  // Configuration register contents.
  typedef struct packed {
    logic [11:0]        months;
    logic [15:0]        days;
    logic               has_time;
    logic signed [31:0] origin;
  } cfg_t;

  // One classified word as it travels from the front end to the back end.
  typedef struct packed {
    logic        month;
    logic        bypass;
    status_t     status;
    logic [31:0] val;
    logic [31:0] base;
    logic [31:0] dvnd;
    logic [15:0] dvsr;
  } item_t;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Day count offsets. The era bias keeps the day-to-era division unsigned.
  localparam logic [33:0] ZU_OFFSET   = 34'd2148356325;  // 730425 + 14700 * 146097
  localparam logic [32:0] DAYS_ERA    = 33'd146097;
  localparam logic [15:0] M_ERA       = 16'(64'd8589934592 / 64'd146097);
  localparam logic [26:0] YEAR_BIAS   = 27'd5880000;     // 14700 * 400
  // Month index offsets for the month-to-day conversion.
  localparam logic [27:0] T2_OFFSET   = 28'd71999998;    // 15000 * 4800 - 2
  localparam logic [27:0] MONTHS_ERA  = 28'd4800;
  localparam logic [15:0] M_MERA      = 16'(64'd268435456 / 64'd4800);
  localparam logic [34:0] DAY_BIAS    = 35'd2192185425;  // 15000 * 146097 + 730425

  // Reciprocals for the narrow constant divisions (20-bit dividends).
  localparam logic [20:0] M_1460  = 21'((1 << 20) / 1460);
  localparam logic [20:0] M_36524 = 21'((1 << 20) / 36524);
  localparam logic [20:0] M_365   = 21'((1 << 20) / 365);
  localparam logic [20:0] M_100   = 21'((1 << 20) / 100);
  localparam logic [20:0] M_153   = 21'((1 << 20) / 153);
  localparam logic [20:0] M_12    = 21'((1 << 20) / 12);

  // Quotient of a 20-bit value by a constant: reciprocal estimate, then one
  // correction step, since the estimate is at most one short.
  function automatic logic [19:0] div_small(input logic [19:0] x, input logic [19:0] c,
                                            input logic [20:0] m);
    logic [40:0] p;
    logic [19:0] qe;
    logic [39:0] qc;
    logic [19:0] r;
    p  = {21'd0, x} * {20'd0, m};
    qe = p[39:20];
    qc = {20'd0, qe} * {20'd0, c};
    r  = x - qc[19:0];
    if (r >= c) begin
      qe = qe + 20'd1;
    end
    return qe;
  endfunction

  // Day of the March-based year on which each month starts.
  function automatic logic [8:0] month_start(input logic [3:0] mi);
    logic [8:0] s;
    unique case (mi)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/date_bucket_truncate_core.sv =====
// Date bucket truncation core: top level with the configuration registers.
// Depends on dbt_pkg, dbt_front, dbt_queue, dbt_back and the defines header.
//
// The core maps a date, a signed day count from 2000-01-01, to the first day
// of its bucket, either a fixed number of days or of calendar months counted
// from the origin date; the two 32-bit extremes pass through as infinities and
// bad settings or dates before the origin give a status code and a zero date.
// It takes one word per clock cycle when the output is not stalled. A word
// passes through the front end, the four-word queue and the back end, whose
// length is set by the 32-stage restoring divider. The input stalls only
// while the queue is full. The user must write the registers only while no
// word is in flight; the core itself does not enforce it.
`include "date_bucket_truncate_core_defines.svh"

module date_bucket_truncate_core import dbt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_day_number,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_bucket_day_number,
  output logic [2:0]         out_status,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  cfg_t  cfg_r;
  cfg_t  cfg_nxt;
  logic  q_push, q_pop, q_full, q_empty;
  item_t q_in, q_out;

  // Register writes.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MONTHS:   cfg_nxt.months   = cfg_data[11:0];
        CFG_DAYS:     cfg_nxt.days     = cfg_data[15:0];
        CFG_HAS_TIME: cfg_nxt.has_time = cfg_data[0];
        CFG_ORIGIN:   cfg_nxt.origin   = cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.months   <= 12'd0;
      cfg_r.days     <= 16'd1;
      cfg_r.has_time <= 1'b0;
      cfg_r.origin   <= 32'sd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  dbt_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_day_number (in_day_number),
    .cfg           (cfg_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (q_in)
  );

  dbt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .pop_item  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  dbt_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_empty               (q_empty),
    .q_item                (q_out),
    .q_pop                 (q_pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_bucket_day_number (out_bucket_day_number),
    .out_status            (out_status)
  );

  // Error words always carry a zero date.
  `DBT_ASSERT_IMP(a_err_zero, out_valid && (out_status != ST_OK), out_bucket_day_number == 32'sd0)
  // The front end only holds off the input when the queue is full.
  `DBT_ASSERT_IMP(a_stall_full, in_stall, q_full)
  // The back end never pops an empty queue.
  `DBT_ASSERT_IMP(a_pop_nonempty, q_pop, !q_empty)
  // An empty queue cannot be full in the next cycle.
  `DBT_ASSERT_NXT(a_no_jump_full, q_empty, !q_full)

endmodule

// ===== rtl/dbt_queue.sv =====
// Short word queue between the front end and the back end.
// Depends on dbt_pkg for the item type and the depth.
module dbt_queue import dbt_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t pop_item,
  output logic  full,
  output logic  empty
);

  item_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic [QCNT_W-1:0] cnt_nxt;

  assign full     = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_item = mem_r[rd_ptr_r];

  // Occupancy follows the push and pop strobes.
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  // Pointers and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/dbt_front.sv =====
// Front end: takes input words, converts the date and the origin to month
// indices over seven stages and classifies each word. Depends on dbt_pkg.
module dbt_front import dbt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_day_number,
  input  cfg_t               cfg,
  input  logic               q_full,
  output logic               q_push,
  output item_t              q_item
);

  logic               en;
  logic [7:1]         vld_r;
  logic signed [31:0] day_r [1:7];
  logic signed [31:0] lane_src [2];
  logic signed [27:0] mon7_r [2];
  logic               first7_r [2];

  // The whole front advances together unless its last word cannot enter the queue.
  assign en       = !(vld_r[7] && q_full);
  assign in_stall = !en;
  assign q_push   = vld_r[7] && !q_full;

  assign lane_src[0] = in_day_number;
  assign lane_src[1] = cfg.origin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[6:1], in_valid};
    end
  end

  // The raw date travels alongside for the infinity and day-mode tests.
  always_ff @(posedge clk) begin
    if (en) begin
      day_r[1] <= in_day_number;
    end
  end

  for (genvar k = 2; k <= 7; k++) begin : g_day
    always_ff @(posedge clk) begin
      if (en) begin
        day_r[k] <= day_r[k-1];
      end
    end
  end

  // Lane 0 converts the date, lane 1 the origin, in identical stages.
  for (genvar g = 0; g < 2; g++) begin : g_lane
    logic [33:0]        zu_sum;
    logic [32:0]        zu1_r, zu2_r;
    logic [48:0]        era_prod;
    logic [15:0]        qe2_r;
    logic [32:0]        rem3;
    logic [32:0]        qc3;
    logic [15:0]        era3_r, era4_r, era5_r;
    logic [17:0]        doe3_r, doe4_r, doe5_r;
    logic [19:0]        t4_nxt;
    logic [17:0]        t4_r;
    logic [8:0]         yoe5_r;
    logic [17:0]        doy_full;
    logic [8:0]         doy6_r;
    logic [26:0]        ym_full;
    logic signed [23:0] ym6_r;
    logic [19:0]        mp_full;
    logic [3:0]         mp7;

    // Stage 1: bias the day count so that eras are non-negative.
    assign zu_sum = {{2{lane_src[g][31]}}, lane_src[g]} + ZU_OFFSET;

    // Stage 2: reciprocal estimate of the era.
    assign era_prod = {16'd0, zu1_r} * {33'd0, M_ERA};

    // Stage 3: correct the era estimate and form the day of the era.
    assign qc3  = {17'd0, qe2_r} * DAYS_ERA;
    assign rem3 = zu2_r - qc3;

    // Stage 4: leap-day adjusted day count within the era.
    assign t4_nxt = {2'd0, doe3_r}
                    - div_small({2'd0, doe3_r}, 20'd1460, M_1460)
                    + div_small({2'd0, doe3_r}, 20'd36524, M_36524)
                    - ((doe3_r == 18'd146096) ? 20'd1 : 20'd0);

    // Stage 6: day of the March-based year and the March-based year number.
    assign doy_full = doe5_r - (18'(yoe5_r) * 18'd365 + 18'(yoe5_r[8:2])
                      - 18'(div_small({11'd0, yoe5_r}, 20'd100, M_100)));
    assign ym_full  = 27'(era5_r) * 27'd400 + 27'(yoe5_r) - YEAR_BIAS;

    // Stage 7: month of the year, absolute month index, first-of-month flag.
    assign mp_full = div_small(20'(doy6_r) * 20'd5 + 20'd2, 20'd153, M_153);
    assign mp7     = mp_full[3:0];

    always_ff @(posedge clk) begin
      if (en) begin
        zu1_r <= zu_sum[32:0];
        zu2_r <= zu1_r;
        qe2_r <= era_prod[48:33];
        if (rem3 >= DAYS_ERA) begin
          era3_r <= qe2_r + 16'd1;
          doe3_r <= 18'(rem3 - DAYS_ERA);
        end else begin
          era3_r <= qe2_r;
          doe3_r <= rem3[17:0];
        end
        era4_r      <= era3_r;
        doe4_r      <= doe3_r;
        t4_r        <= t4_nxt[17:0];
        era5_r      <= era4_r;
        doe5_r      <= doe4_r;
        yoe5_r      <= 9'(div_small({2'd0, t4_r}, 20'd365, M_365));
        doy6_r      <= doy_full[8:0];
        ym6_r       <= ym_full[23:0];
        mon7_r[g]   <= {{4{ym6_r[23]}}, ym6_r} * 28'sd12 + 28'(mp7) + 28'sd2;
        first7_r[g] <= (doy6_r == month_start(mp7));
      end
    end
  end

  // Classification: interval and origin checks first, then infinities, then the mode.
  always_comb begin
    q_item        = '0;
    q_item.status = ST_OK;
    q_item.month  = (cfg.months != 12'd0);
    priority if (cfg.has_time || (cfg.months != 12'd0 && cfg.days != 16'd0)) begin
      q_item.bypass = 1'b1;
      q_item.status = ST_TIME;
    end else if (cfg.months == 12'd0 && cfg.days == 16'd0) begin
      q_item.bypass = 1'b1;
      q_item.status = ST_EMPTY;
    end else if (cfg.months != 12'd0 && !first7_r[1]) begin
      q_item.bypass = 1'b1;
      q_item.status = ST_ORIGIN;
    end else if (day_r[7] == 32'sh8000_0000 || day_r[7] == 32'sh7fff_ffff) begin
      q_item.bypass = 1'b1;
      q_item.val    = day_r[7];
    end else if (cfg.months != 12'd0) begin
      if (mon7_r[0] < mon7_r[1]) begin
        q_item.bypass = 1'b1;
        q_item.status = ST_BEFORE;
      end else begin
        q_item.dvnd = 32'(mon7_r[0] - mon7_r[1]);
        q_item.base = {{4{mon7_r[1][27]}}, mon7_r[1]};
        q_item.dvsr = {4'd0, cfg.months};
      end
    end else begin
      if (day_r[7] < cfg.origin) begin
        q_item.bypass = 1'b1;
        q_item.status = ST_BEFORE;
      end else begin
        q_item.dvnd = day_r[7] - cfg.origin;
        q_item.base = cfg.origin;
        q_item.dvsr = cfg.days;
      end
    end
  end

endmodule

// ===== rtl/dbt_back.sv =====
// Back end: 32-stage divider, rescale by the bucket width and, in month
// mode, conversion of the bucket month back to a day count. Depends on dbt_pkg.
module dbt_back import dbt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  item_t              q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_bucket_day_number,
  output logic [2:0]         out_status
);

  typedef struct packed {
    logic        vld;
    logic        month;
    logic        bypass;
    status_t     status;
    logic [31:0] val;
    logic [31:0] base;
    logic [15:0] dvsr;
    logic [31:0] w;
    logic [15:0] rem;
  } dv_t;

  typedef struct packed {
    logic        vld;
    logic        month;
    logic        bypass;
    status_t     status;
    logic [31:0] val;
  } ctl_t;

  // One restoring division step: shift in a dividend bit, subtract if it fits.
  function automatic dv_t div_step(input dv_t s);
    dv_t         o;
    logic [16:0] trial;
    o     = s;
    trial = {s.rem, s.w[31]};
    if (trial >= {1'b0, s.dvsr}) begin
      o.rem = 16'(trial - {1'b0, s.dvsr});
      o.w   = {s.w[30:0], 1'b1};
    end else begin
      o.rem = trial[15:0];
      o.w   = {s.w[30:0], 1'b0};
    end
    return o;
  endfunction

  logic        en;
  dv_t         stg_r [0:32];
  ctl_t        pc_r, rc_r, qc_r, cc_r, yc_r, dc_r;
  ctl_t        rc_nxt;
  logic [31:0] p_base_r;
  logic [47:0] p_prod_r;
  logic [27:0] t_sum;
  logic [27:0] r_t2u_r, q_t2u_r;
  logic [43:0] mera_prod;
  logic [15:0] q_qe_r;
  logic [27:0] c_rem;
  logic [15:0] c_era_r, y_era_r, d_era_r;
  logic [12:0] c_moe_r;
  logic [19:0] yoe_full;
  logic [8:0]  y_yoe_r;
  logic [12:0] mi_full;
  logic [3:0]  y_mi_r;
  logic [17:0] d_doe_r;
  logic [34:0] days_full;
  logic        out_vld_r;
  logic [31:0] out_val_r;
  status_t     out_st_r;

  // The whole back end advances while the output register can move on.
  assign en    = !out_vld_r || !out_stall;
  assign q_pop = en && !q_empty;

  // Stage 0: load from the queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r[0].vld <= 1'b0;
    end else if (en) begin
      stg_r[0].vld <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg_r[0].month  <= q_item.month;
      stg_r[0].bypass <= q_item.bypass;
      stg_r[0].status <= q_item.status;
      stg_r[0].val    <= q_item.val;
      stg_r[0].base   <= q_item.base;
      stg_r[0].dvsr   <= q_item.dvsr;
      stg_r[0].w      <= q_item.dvnd;
      stg_r[0].rem    <= 16'd0;
    end
  end

  // Divider stages, one quotient bit each.
  for (genvar k = 1; k <= 32; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stg_r[k].vld <= 1'b0;
      end else if (en) begin
        stg_r[k] <= div_step(stg_r[k-1]);
      end
    end
  end

  // Month-index arithmetic: bucket start month shifted to a March-based,
  // era-biased index, then its era estimate.
  assign t_sum     = p_base_r[27:0] + p_prod_r[27:0];
  assign mera_prod = {16'd0, r_t2u_r} * {28'd0, M_MERA};
  assign c_rem     = q_t2u_r - 28'({12'd0, q_qe_r} * MONTHS_ERA);
  assign yoe_full  = div_small({7'd0, c_moe_r}, 20'd12, M_12);
  assign mi_full   = c_moe_r - 13'(yoe_full[8:0] * 13'd12);
  assign days_full = {19'd0, d_era_r} * 35'd146097 + 35'(d_doe_r) - DAY_BIAS;

  // Day-mode result: the origin plus the rounded-down offset.
  always_comb begin
    rc_nxt = pc_r;
    if (!pc_r.month && !pc_r.bypass) begin
      rc_nxt.val = p_base_r + p_prod_r[31:0];
    end
  end

  // Control of the tail stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r.vld  <= 1'b0;
      rc_r.vld  <= 1'b0;
      qc_r.vld  <= 1'b0;
      cc_r.vld  <= 1'b0;
      yc_r.vld  <= 1'b0;
      dc_r.vld  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      pc_r      <= '{vld: stg_r[32].vld, month: stg_r[32].month, bypass: stg_r[32].bypass,
                     status: stg_r[32].status, val: stg_r[32].val};
      rc_r      <= rc_nxt;
      qc_r      <= rc_r;
      cc_r      <= qc_r;
      yc_r      <= cc_r;
      dc_r      <= yc_r;
      out_vld_r <= dc_r.vld;
    end
  end

  // Datapath of the tail stages.
  always_ff @(posedge clk) begin
    if (en) begin
      p_base_r <= stg_r[32].base;
      p_prod_r <= {16'd0, stg_r[32].w} * {32'd0, stg_r[32].dvsr};
      r_t2u_r  <= t_sum + T2_OFFSET;
      q_t2u_r  <= r_t2u_r;
      q_qe_r   <= mera_prod[43:28];
      if (c_rem >= MONTHS_ERA) begin
        c_era_r <= q_qe_r + 16'd1;
        c_moe_r <= 13'(c_rem - MONTHS_ERA);
      end else begin
        c_era_r <= q_qe_r;
        c_moe_r <= c_rem[12:0];
      end
      y_era_r  <= c_era_r;
      y_yoe_r  <= yoe_full[8:0];
      y_mi_r   <= mi_full[3:0];
      d_era_r  <= y_era_r;
      d_doe_r  <= 18'(y_yoe_r) * 18'd365 + 18'(y_yoe_r[8:2])
                  - 18'(div_small({11'd0, y_yoe_r}, 20'd100, M_100))
                  + 18'(month_start(y_mi_r));
      out_st_r <= dc_r.status;
      if (dc_r.month && !dc_r.bypass) begin
        out_val_r <= days_full[31:0];
      end else begin
        out_val_r <= dc_r.val;
      end
    end
  end

  assign out_valid             = out_vld_r;
  assign out_bucket_day_number = out_val_r;
  assign out_status            = out_st_r;

endmodule
